@@ src/lc3ie_pkg.sv @@
// Package for the LC-3 instruction executor: opcodes, trap vectors,
// condition codes, sequencer states and small decode helpers.
// Used by src/lc3_instruction_executor.sv; depends on nothing else.
package lc3ie_pkg;

   localparam int MEM_WORDS_DEF = 65536;

   typedef enum logic [3:0] {
      OP_BR   = 4'd0,
      OP_ADD  = 4'd1,
      OP_LD   = 4'd2,
      OP_ST   = 4'd3,
      OP_JSR  = 4'd4,
      OP_AND  = 4'd5,
      OP_LDR  = 4'd6,
      OP_STR  = 4'd7,
      OP_RTI  = 4'd8,
      OP_NOT  = 4'd9,
      OP_LDI  = 4'd10,
      OP_STI  = 4'd11,
      OP_JMP  = 4'd12,
      OP_RSV  = 4'd13,
      OP_LEA  = 4'd14,
      OP_TRAP = 4'd15
   } opcode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_EXEC,
      ST_INDIR,
      ST_LOAD,
      ST_STIW
   } state_type;

   localparam logic       REQ_WRITE = 1'b0;
   localparam logic       REQ_EXEC  = 1'b1;

   localparam logic [7:0] TRAP_GETC = 8'h20;
   localparam logic [7:0] TRAP_OUT  = 8'h21;
   localparam logic [7:0] TRAP_IN   = 8'h23;
   localparam logic [7:0] TRAP_HALT = 8'h25;

   localparam logic [1:0] CC_NEG  = 2'd0;
   localparam logic [1:0] CC_ZERO = 2'd1;
   localparam logic [1:0] CC_POS  = 2'd2;

   localparam logic [2:0] REG_R0 = 3'd0;
   localparam logic [2:0] REG_R7 = 3'd7;

   function automatic logic [1:0] cc_of(input logic [15:0] v);
      logic [1:0] c;
      if (v == 16'd0) begin
         c = CC_ZERO;
      end else if (v[15]) begin
         c = CC_NEG;
      end else begin
         c = CC_POS;
      end
      return c;
   endfunction

endpackage

@@ src/lc3_instruction_executor.sv @@
// LC-3 core: program memory, register file and a fetch/execute sequencer.
// Depends on lc3ie_pkg.
//
//  Channel | Dir | Handshake          | Payload
//  req     | in  | req_tvalid/tready  | tuser: op; tdata: address, data, char_in
//  rsp     | out | rsp_tvalid/tready  | tdata: next_pc, instruction, cond_code,
//          |     |                    |        running, char_valid, char_out
//  csr     | in  | csr_we             | csr_wdata: start_pc (loads the PC)
//
// A memory write is taken in the idle state; an instruction passes decode and
// execute, then LD and LDR a load state, LDI an indirect read and a load, STI
// an indirect store, each on a memory read. The result moves to the output
// register when the sequencer is idle and that register is free. After reset
// the memory is zeroed with req_tready low; csr writes are taken throughout.
// A stalled output register holds the next result back in the sequencer.
module lc3_instruction_executor
   import lc3ie_pkg::*;
#(
   parameter int MEM_WORDS = MEM_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // address[15:0], data[31:16], char_in[39:32]
   input  logic [0:0]  req_tuser,   // op[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // next_pc[15:0], instruction[31:16],
                                    // cond_code[33:32], running[34],
                                    // char_valid[35], char_out[43:36], zero pad
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int AW = $clog2(MEM_WORDS);

   logic [15:0]   mem [MEM_WORDS];
   logic [15:0]   mem_rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [15:0]   mem_wdata;
   logic [AW-1:0] mem_raddr;

   logic [15:0] rf [8];
   logic [7:0]  rf_valid_ff;
   logic        rf_we;
   logic [2:0]  rf_waddr;
   logic [15:0] rf_wdata;
   logic        rf_re;
   logic [2:0]  rf_ra;
   logic [2:0]  rf_rb;
   logic [15:0] rfa_ff;
   logic [15:0] rfb_ff;

   state_type     state_ff, state_in;
   logic [15:0]   pc_ff, pc_in;
   logic [1:0]    cc_ff, cc_in;
   logic          run_ff, run_in;
   logic          pend_ff, pend_in;
   logic [15:0]   ir_ff, ir_in;
   logic [7:0]    ch_ff, ch_in;
   logic          cv_ff, cv_in;
   logic [7:0]    co_ff, co_in;
   logic          r0w_ff, r0w_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          rsp_valid_ff;
   logic [43:0]   rsp_data_ff;

   logic        can_load;
   logic        load_out;
   logic        accept;
   logic [15:0] req_address;
   logic [15:0] req_data;
   logic [7:0]  req_char;
   opcode_type  dec_opc;
   opcode_type  opc;
   logic [15:0] off9;
   logic [15:0] off6;
   logic [15:0] off11;
   logic [15:0] opb;
   logic [15:0] alu;
   logic [15:0] pc_off9;
   logic [15:0] base_off6;
   logic        br_bit;

   assign req_address = req_tdata[15:0];
   assign req_data    = req_tdata[31:16];
   assign req_char    = req_tdata[39:32];

   assign can_load   = !rsp_valid_ff || rsp_tready;
   assign load_out   = (state_ff == ST_IDLE) && pend_ff && can_load;
   assign req_tready = (state_ff == ST_IDLE) && (!pend_ff || can_load);
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};

   assign dec_opc   = opcode_type'(mem_rdata_ff[15:12]);
   assign opc       = opcode_type'(ir_ff[15:12]);
   assign off9      = {{7{ir_ff[8]}}, ir_ff[8:0]};
   assign off6      = {{10{ir_ff[5]}}, ir_ff[5:0]};
   assign off11     = {{5{ir_ff[10]}}, ir_ff[10:0]};
   assign opb       = ir_ff[5] ? {{11{ir_ff[4]}}, ir_ff[4:0]} : rfb_ff;
   assign alu       = (opc == OP_ADD) ? rfa_ff + opb : rfa_ff & opb;
   assign pc_off9   = pc_ff + off9;
   assign base_off6 = rfa_ff + off6;

   always_comb begin
      unique case (cc_ff)
         CC_NEG:  br_bit = ir_ff[11];
         CC_ZERO: br_bit = ir_ff[10];
         default: br_bit = ir_ff[9];
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == {AW{1'b1}}) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && req_tuser[0] == REQ_EXEC && run_ff) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = (mem_rdata_ff == 16'd0) ? ST_IDLE : ST_EXEC;
         end
         ST_EXEC: begin
            unique case (opc)
               OP_LD, OP_LDR: state_in = ST_LOAD;
               OP_LDI:        state_in = ST_INDIR;
               OP_STI:        state_in = ST_STIW;
               default:       state_in = ST_IDLE;
            endcase
         end
         ST_INDIR: state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_IDLE;
         ST_STIW:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory port control.
   always_comb begin
      pc_in     = pc_ff;
      cc_in     = cc_ff;
      run_in    = run_ff;
      pend_in   = pend_ff;
      ir_in     = ir_ff;
      ch_in     = ch_ff;
      cv_in     = cv_ff;
      co_in     = co_ff;
      r0w_in    = r0w_ff;
      clr_in    = clr_ff;
      mem_we    = 1'b0;
      mem_waddr = pc_ff[AW-1:0];
      mem_wdata = rfb_ff;
      mem_raddr = pc_ff[AW-1:0];
      rf_we     = 1'b0;
      rf_waddr  = ir_ff[11:9];
      rf_wdata  = alu;
      rf_re     = 1'b0;
      rf_ra     = mem_rdata_ff[8:6];
      rf_rb     = mem_rdata_ff[2:0];

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 16'd0;
            clr_in    = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            // A GETC or IN trap leaves its R0 write for this cycle.
            if (r0w_ff) begin
               rf_we    = 1'b1;
               rf_waddr = REG_R0;
               rf_wdata = {8'd0, ch_ff};
               r0w_in   = 1'b0;
            end
            if (load_out) pend_in = 1'b0;
            if (accept) begin
               pend_in = 1'b1;
               ir_in   = 16'd0;
               cv_in   = 1'b0;
               co_in   = 8'd0;
               ch_in   = req_char;
               if (req_tuser[0] == REQ_WRITE) begin
                  mem_we    = 1'b1;
                  mem_waddr = req_address[AW-1:0];
                  mem_wdata = req_data;
               end else if (run_ff) begin
                  pend_in = 1'b0;
                  pc_in   = pc_ff + 16'd1;
               end
            end
         end
         ST_DECODE: begin
            ir_in = mem_rdata_ff;
            if (mem_rdata_ff == 16'd0) begin
               run_in  = 1'b0;
               pend_in = 1'b1;
            end else begin
               rf_re = 1'b1;
               if (dec_opc == OP_TRAP) rf_ra = REG_R0;
               if (dec_opc == OP_ST || dec_opc == OP_STR || dec_opc == OP_STI) begin
                  rf_rb = mem_rdata_ff[11:9];
               end
            end
         end
         ST_EXEC: begin
            pend_in = 1'b1;
            unique case (opc)
               OP_BR: begin
                  if (br_bit) pc_in = pc_off9;
               end
               OP_ADD, OP_AND: begin
                  rf_we = 1'b1;
                  cc_in = cc_of(alu);
               end
               OP_NOT: begin
                  rf_we    = 1'b1;
                  rf_wdata = ~rfa_ff;
                  cc_in    = cc_of(~rfa_ff);
               end
               OP_LEA: begin
                  rf_we    = 1'b1;
                  rf_wdata = pc_off9;
                  cc_in    = cc_of(pc_off9);
               end
               OP_JMP: pc_in = rfa_ff;
               OP_JSR: begin
                  rf_we    = 1'b1;
                  rf_waddr = REG_R7;
                  rf_wdata = pc_ff;
                  pc_in    = ir_ff[11] ? pc_ff + off11 : rfa_ff;
               end
               OP_TRAP: begin
                  rf_we    = 1'b1;
                  rf_waddr = REG_R7;
                  rf_wdata = pc_ff;
                  if (ir_ff[7:0] == TRAP_GETC || ir_ff[7:0] == TRAP_IN) begin
                     r0w_in = 1'b1;
                  end else if (ir_ff[7:0] == TRAP_OUT) begin
                     cv_in = 1'b1;
                     co_in = rfa_ff[7:0];
                  end else if (ir_ff[7:0] == TRAP_HALT) begin
                     run_in = 1'b0;
                  end
               end
               OP_LD, OP_LDI, OP_STI: begin
                  pend_in   = 1'b0;
                  mem_raddr = pc_off9[AW-1:0];
               end
               OP_LDR: begin
                  pend_in   = 1'b0;
                  mem_raddr = base_off6[AW-1:0];
               end
               OP_ST: begin
                  mem_we    = 1'b1;
                  mem_waddr = pc_off9[AW-1:0];
               end
               OP_STR: begin
                  mem_we    = 1'b1;
                  mem_waddr = base_off6[AW-1:0];
               end
               default: begin
               end
            endcase
         end
         ST_INDIR: begin
            mem_raddr = mem_rdata_ff[AW-1:0];
         end
         ST_LOAD: begin
            pend_in  = 1'b1;
            rf_we    = 1'b1;
            rf_wdata = mem_rdata_ff;
            cc_in    = cc_of(mem_rdata_ff);
         end
         ST_STIW: begin
            pend_in   = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = mem_rdata_ff[AW-1:0];
         end
         default: begin
         end
      endcase

      if (csr_we) pc_in = csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_raddr];
   end

   // Register file entries read as zero until first written after reset.
   always_ff @(posedge clock) begin
      if (rf_we) rf[rf_waddr] <= rf_wdata;
      if (rf_re) begin
         rfa_ff <= rf_valid_ff[rf_ra] ? rf[rf_ra] : 16'd0;
         rfb_ff <= rf_valid_ff[rf_rb] ? rf[rf_rb] : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= 8'd0;
      end else if (rf_we) begin
         rf_valid_ff[rf_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pc_ff        <= 16'd0;
         cc_ff        <= CC_ZERO;
         run_ff       <= 1'b1;
         pend_ff      <= 1'b0;
         r0w_ff       <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         cc_ff    <= cc_in;
         run_ff   <= run_in;
         pend_ff  <= pend_in;
         r0w_ff   <= r0w_in;
         clr_ff   <= clr_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ir_ff <= ir_in;
      ch_ff <= ch_in;
      cv_ff <= cv_in;
      co_ff <= co_in;
      if (load_out) rsp_data_ff <= {co_ff, cv_ff, run_ff, cc_ff, ir_ff, pc_ff};
   end

endmodule

@@ tb/tb_lc3_instruction_executor.sv @@
// Self-checking testbench for lc3_instruction_executor: loads instruction words
// into memory, executes them and checks every result word against a predictor.
// Depends on lc3ie_pkg and src/lc3_instruction_executor.sv.
module tb_lc3_instruction_executor;
   import lc3ie_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic        op;
      logic [15:0] addr;
      logic [15:0] data;
      logic [7:0]  ch;
   } cmd_t;

   typedef struct packed {
      logic [15:0] next_pc;
      logic [15:0] instruction;
      logic [1:0]  cc;
      logic        running;
      logic        char_valid;
      logic [7:0]  char_out;
   } outcome_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // address[15:0], data[31:16], char_in[39:32]
   logic [0:0]  req_tuser = '0;   // op[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // next_pc, instruction, cond_code, running,
                                  // char_valid, char_out, zero pad
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   lc3_instruction_executor u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Shadow copy of the core state.
   logic [15:0] core_mem [0:65535];
   logic [15:0] core_regs [0:7];
   logic [15:0] core_pc;
   logic [1:0]  core_cc;
   logic        core_run;

   cmd_t     pending_words[$];
   outcome_t expected_outcomes[$];
   int       error_count = 0;
   int       cycle_count = 0;
   int       send_idle_pct = 0;
   int       recv_stall_pct = 0;
   int       hold_requests = 0;
   int       hold_served = 0;
   int       hold_left = 0;

   function automatic logic [15:0] sign_ext(input logic [15:0] v, input int bits);
      logic [15:0] mask;
      mask = (16'd1 << bits) - 16'd1;
      v = v & mask;
      if (v[bits-1]) begin
         v = v | ~mask;
      end
      return v;
   endfunction

   function automatic logic [1:0] cc_for(input logic [15:0] v);
      return (v == 16'd0) ? CC_ZERO : (v[15] ? CC_NEG : CC_POS);
   endfunction

   function automatic outcome_t predict_step(input cmd_t c);
      outcome_t    o;
      logic [15:0] w, pc, off9, off6, r, t;
      logic [2:0]  dr, sr1;
      logic        take;
      o = '0;
      w = 16'd0;
      if (c.op == REQ_WRITE) begin
         core_mem[c.addr] = c.data;
      end else if (core_run) begin
         w = core_mem[core_pc];
         core_pc = core_pc + 16'd1;
         pc = core_pc;
         dr = w[11:9];
         sr1 = w[8:6];
         off9 = sign_ext(w, 9);
         off6 = sign_ext(w, 6);
         if (w == 16'd0) begin
            core_run = 1'b0;
         end else begin
            case (opcode_type'(w[15:12]))
               OP_BR: begin
                  take = (core_cc == CC_NEG) ? w[11] : (core_cc == CC_ZERO) ? w[10] : w[9];
                  if (take) core_pc = pc + off9;
               end
               OP_ADD, OP_AND: begin
                  t = w[5] ? sign_ext(w, 5) : core_regs[w[2:0]];
                  r = (w[15:12] == OP_ADD) ? core_regs[sr1] + t : core_regs[sr1] & t;
                  core_regs[dr] = r;
                  core_cc = cc_for(r);
               end
               OP_LD, OP_LEA, OP_LDI, OP_LDR, OP_NOT: begin
                  case (opcode_type'(w[15:12]))
                     OP_LD:   r = core_mem[pc + off9];
                     OP_LEA:  r = pc + off9;
                     OP_LDI:  r = core_mem[core_mem[pc + off9]];
                     OP_LDR:  r = core_mem[core_regs[sr1] + off6];
                     default: r = ~core_regs[sr1];
                  endcase
                  core_regs[dr] = r;
                  core_cc = cc_for(r);
               end
               OP_ST:  core_mem[pc + off9] = core_regs[dr];
               OP_STR: core_mem[core_regs[sr1] + off6] = core_regs[dr];
               OP_STI: core_mem[core_mem[pc + off9]] = core_regs[dr];
               OP_JSR: begin
                  t = core_regs[sr1];
                  core_regs[REG_R7] = pc;
                  core_pc = w[11] ? pc + sign_ext(w, 11) : t;
               end
               OP_JMP: core_pc = core_regs[sr1];
               OP_TRAP: begin
                  core_regs[REG_R7] = pc;
                  if (w[7:0] == TRAP_GETC || w[7:0] == TRAP_IN) begin
                     core_regs[REG_R0] = {8'd0, c.ch};
                  end else if (w[7:0] == TRAP_OUT) begin
                     o.char_valid = 1'b1;
                     o.char_out = core_regs[REG_R0][7:0];
                  end else if (w[7:0] == TRAP_HALT) begin
                     core_run = 1'b0;
                  end
               end
               default: ;
            endcase
         end
      end
      o.next_pc = core_pc;
      o.instruction = w;
      o.cc = core_cc;
      o.running = core_run;
      return o;
   endfunction

   task automatic queue_word(input logic op, input logic [15:0] addr,
                             input logic [15:0] data, input logic [7:0] ch);
      cmd_t c;
      c = {op, addr, data, ch};
      expected_outcomes.push_back(predict_step(c));
      pending_words.push_back(c);
   endtask

   // Place an instruction at the current PC, then execute it.
   task automatic run_instr(input logic [15:0] w);
      queue_word(REQ_WRITE, core_pc, w, 8'($urandom));
      queue_word(REQ_EXEC, 16'($urandom), 16'($urandom), 8'($urandom));
   endtask

   function automatic bit keeps_running(input logic [15:0] w);
      return w != 16'd0 && !(w[15:12] == OP_TRAP && w[7:0] == TRAP_HALT);
   endfunction

   function automatic logic [15:0] random_instr();
      logic [15:0] w;
      do begin
         w = 16'($urandom);
         if (w[15:12] == OP_TRAP) begin
            case ($urandom_range(3))
               0: w[7:0] = TRAP_GETC;
               1: w[7:0] = TRAP_OUT;
               2: w[7:0] = TRAP_IN;
               default: ;
            endcase
         end
      end while (!keeps_running(w));
      return w;
   endfunction

   task automatic wait_drained();
      while (pending_words.size() != 0 || expected_outcomes.size() != 0) begin
         @(posedge clock);
      end
      repeat (12) @(posedge clock);
   endtask

   task automatic load_origin(input logic [15:0] v);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      core_pc = v;
   endtask

   task automatic random_burst(input int count);
      int n, pick;
      n = 0;
      while (n < count) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            queue_word(REQ_WRITE, 16'($urandom), 16'($urandom), 8'($urandom));
            n++;
         end else if (pick < 22 && keeps_running(core_mem[core_pc])) begin
            queue_word(REQ_EXEC, 16'($urandom), 16'($urandom), 8'($urandom));
            n++;
         end else begin
            run_instr(random_instr());
            n += 2;
         end
      end
   endtask

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("ERROR at cycle %0d: %s is %h, expected %h", cycle_count, field, got, want);
      error_count++;
   endtask

   // Sender: offers pending words, idling at random.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cmd_t c;
            c = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= c.op;
            req_tdata <= {c.ch, c.data, c.addr};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus long hold-offs on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: each result word is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_outcomes.size() == 0) begin
            $display("ERROR at cycle %0d: result word %h with nothing expected",
                     cycle_count, rsp_tdata);
            error_count++;
         end else begin
            outcome_t e;
            e = expected_outcomes.pop_front();
            if (rsp_tdata[15:0] !== e.next_pc)
               report_mismatch("next_pc", rsp_tdata[15:0], e.next_pc);
            if (rsp_tdata[31:16] !== e.instruction)
               report_mismatch("instruction", rsp_tdata[31:16], e.instruction);
            if (rsp_tdata[33:32] !== e.cc)
               report_mismatch("cond_code", 16'(rsp_tdata[33:32]), 16'(e.cc));
            if (rsp_tdata[34] !== e.running)
               report_mismatch("running", 16'(rsp_tdata[34]), 16'(e.running));
            if (rsp_tdata[35] !== e.char_valid)
               report_mismatch("char_valid", 16'(rsp_tdata[35]), 16'(e.char_valid));
            if (rsp_tdata[43:36] !== e.char_out)
               report_mismatch("char_out", 16'(rsp_tdata[43:36]), 16'(e.char_out));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 65536; i++) core_mem[i] = 16'd0;
      for (int i = 0; i < 8; i++) core_regs[i] = 16'd0;
      core_pc = 16'd0;
      core_cc = CC_ZERO;
      core_run = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every opcode, both ADD/AND forms, PC wrap from the top word.
      load_origin(16'hFFFF);
      run_instr({OP_ADD, 3'd1, 3'd0, 1'b1, 5'h10});
      run_instr({OP_ADD, 3'd2, 3'd1, 3'b000, 3'd1});
      run_instr({OP_ADD, 3'd0, 3'd0, 1'b1, 5'h0F});
      run_instr({OP_AND, 3'd3, 3'd2, 1'b1, 5'h0F});
      run_instr({OP_AND, 3'd4, 3'd1, 3'b000, 3'd2});
      run_instr({OP_NOT, 3'd5, 3'd4, 6'h3F});
      run_instr({OP_LEA, 3'd6, 9'h100});
      run_instr({OP_ST,  3'd2, 9'h005});
      run_instr({OP_LD,  3'd0, 9'h004});
      run_instr({OP_STI, 3'd1, 9'h1FD});
      run_instr({OP_LDI, 3'd3, 9'h1FC});
      run_instr({OP_STR, 3'd5, 3'd6, 6'h1F});
      run_instr({OP_LDR, 3'd7, 3'd6, 6'h20});
      run_instr({OP_BR,  3'b000, 9'h001});
      run_instr({OP_BR,  3'b111, 9'h0FF});
      run_instr({OP_JSR, 1'b1, 11'h400});
      run_instr({OP_JSR, 1'b0, 2'b00, 3'd6, 6'h00});
      run_instr({OP_JMP, 3'b000, 3'd7, 6'h00});
      run_instr({OP_RTI, 12'h000});
      run_instr({OP_RSV, 12'hFFF});
      run_instr({OP_TRAP, 4'h0, TRAP_GETC});
      run_instr({OP_TRAP, 4'h0, TRAP_OUT});
      run_instr({OP_TRAP, 4'hF, TRAP_IN});
      run_instr({OP_TRAP, 4'h0, 8'h22});

      load_origin(16'h0000);
      random_burst(400);

      send_idle_pct = 74;
      load_origin(16'($urandom));
      random_burst(350);

      send_idle_pct = 0;
      recv_stall_pct = 74;
      load_origin(16'h3000);
      hold_requests++;
      random_burst(350);

      send_idle_pct = 19;
      recv_stall_pct = 19;
      load_origin(16'($urandom));
      random_burst(350);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      load_origin(16'hFFF0);
      random_burst(250);

      // Stop the core, either by HALT or by fetching a zero word, then poke it.
      if ($urandom_range(1) == 0) begin
         run_instr({OP_TRAP, 4'h0, TRAP_HALT});
      end else begin
         run_instr(16'h0000);
      end
      queue_word(REQ_EXEC, 16'($urandom), 16'($urandom), 8'($urandom));
      queue_word(REQ_WRITE, 16'($urandom), 16'($urandom), 8'($urandom));
      queue_word(REQ_EXEC, 16'($urandom), 16'($urandom), 8'($urandom));

      wait_drained();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
